/* rtl/assert_macros.svh */
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fta_pkg.sv */
// Package: field widths and stage payload types for the truncating adder
`default_nettype none
package fta_pkg;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned SigW  = 24;
  localparam int unsigned MagW  = 25;
  localparam int unsigned AlignLimit = 24;

  // Stage 1 -> 2: aligned significands
  typedef struct packed {
    logic               neg_sum;
    logic               sub;
    logic [ExpW-1:0]    exp_big;
    logic [SigW-1:0]    sig_big;
    logic [SigW-1:0]    sig_small;
  } align_t;

  // Stage 2 -> 3: magnitude
  typedef struct packed {
    logic               neg_sum;
    logic [ExpW-1:0]    exp_big;
    logic [MagW-1:0]    mag;
  } mag_t;
endpackage
`default_nettype wire

/* rtl/fta_align.sv */
// Stage 1 logic: sign, exponent compare and alignment shift
`default_nettype none
module fta_align (
  input  wire logic [31:0]     operand_a,
  input  wire logic [31:0]     operand_b,
  output fta_pkg::align_t      align
);
  logic                       neg_a, neg_b, a_bigger, b_bigger, swap;
  logic [fta_pkg::ExpW-1:0]   exp_a, exp_b, diff;
  logic [fta_pkg::SigW-1:0]   sig_a, sig_b, sig_s;

  always_comb begin
    neg_a = operand_a[31];
    neg_b = operand_b[31];
    exp_a = operand_a[30:23];
    exp_b = operand_b[30:23];
    sig_a = {1'b1, operand_a[22:0]};
    sig_b = {1'b1, operand_b[22:0]};
    a_bigger = (exp_a > exp_b) || ((exp_a == exp_b) && (sig_a > sig_b));
    b_bigger = (exp_a < exp_b) || ((exp_a == exp_b) && (sig_a < sig_b));
    swap = b_bigger;
    diff = (exp_a < exp_b) ? (exp_b - exp_a) : (exp_a - exp_b);
    sig_s = swap ? sig_a : sig_b;
    align.neg_sum   = (neg_a && neg_b) || (neg_a && a_bigger) || (neg_b && b_bigger);
    align.sub       = neg_a ^ neg_b;
    align.exp_big   = (exp_a < exp_b) ? exp_b : exp_a;
    align.sig_big   = swap ? sig_b : sig_a;
    align.sig_small = (diff < fta_pkg::ExpW'(fta_pkg::AlignLimit)) ? (sig_s >> diff) : '0;
  end
endmodule
`default_nettype wire

/* rtl/fta_norm.sv */
// Stage 3 logic: leading-one search, normalising shift and packing
`default_nettype none
module fta_norm (
  input  wire fta_pkg::mag_t   mag_in,
  output logic [31:0]          sum_bits
);
  logic [4:0]                 lead;
  logic                       found;
  logic [fta_pkg::MagW-1:0]   shifted;
  logic [fta_pkg::ExpW-1:0]   exp_out;

  always_comb begin
    lead  = '0;
    found = 1'b0;
    for (int k = 0; k < fta_pkg::MagW; k++) begin
      if (mag_in.mag[k]) begin
        lead  = 5'(k);
        found = 1'b1;
      end
    end
    if (mag_in.mag[24]) begin
      shifted = mag_in.mag >> 1;
    end else begin
      shifted = mag_in.mag << (5'(fta_pkg::FracW) - lead);
    end
    exp_out = mag_in.exp_big + 8'(lead) - 8'(fta_pkg::FracW);
    if (!found) begin
      sum_bits = {mag_in.neg_sum, 31'd0};
    end else begin
      sum_bits = {mag_in.neg_sum, exp_out, shifted[22:0]};
    end
  end
endmodule
`default_nettype wire

/* rtl/float32_truncating_adder.sv */
// Top level: three-stage pipelined single-precision truncating adder
// Usage:
//   Input channel: in_operand_a, in_operand_b with in_valid / in_stall.
//   A word is taken at a rising edge with in_valid high and in_stall low.
//   Result channel: out_sum_bits with out_valid / out_stall.
//   Each word passes the align, magnitude and result registers in order,
//   and out_valid rises once it reaches the result register.
//   Throughput: one word per cycle while out_stall is low; stage 1 aligns,
//   stage 2 adds or subtracts, stage 3 normalises and drives the output register.
//   When out_stall is high a full pipeline holds; a stage with a bubble
//   still fills, so in_stall only rises when all three stages hold words.
//   Synchronous active-low reset clears all valid bits; payload is not reset.
//   No special values: zero, subnormal, infinity and NaN are read as
//   normal numbers and rounding is truncation.
`default_nettype none
module float32_truncating_adder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_sum_bits
);
  fta_pkg::align_t align_nxt, align_r;
  fta_pkg::mag_t   mag_nxt, mag_r;
  logic [31:0]     sum_nxt, sum_r;
  logic            v1_r, v2_r, v3_r;
  logic            en1, en2, en3;

  assign en3 = !v3_r || !out_stall;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  fta_align u_align (.operand_a(in_operand_a), .operand_b(in_operand_b), .align(align_nxt));

  always_comb begin
    mag_nxt.neg_sum = align_r.neg_sum;
    mag_nxt.exp_big = align_r.exp_big;
    if (align_r.sub) begin
      mag_nxt.mag = {1'b0, align_r.sig_big} - {1'b0, align_r.sig_small};
    end else begin
      mag_nxt.mag = {1'b0, align_r.sig_big} + {1'b0, align_r.sig_small};
    end
  end

  fta_norm u_norm (.mag_in(mag_r), .sum_bits(sum_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) align_r <= align_nxt;
    if (en2) mag_r   <= mag_nxt;
    if (en3) sum_r   <= sum_nxt;
  end

  assign out_valid    = v3_r;
  assign out_sum_bits = sum_r;
endmodule
`default_nettype wire

/* rtl/fta_checker.sv */
// Port checker for the truncating adder, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module fta_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_sum_bits
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_sum_bits), "stalled result changed")
  `CHK_IMPLY(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while output free")
  `CHK_NEXT(a_stall_keeps_out, clk, rst_n, in_stall, out_valid, "result dropped while input stalled")
endmodule
bind float32_truncating_adder fta_checker u_fta_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_sum_bits(out_sum_bits)
);
`default_nettype wire
